// ===== rtl/lrs_pkg.sv =====
package lrs_pkg;

	localparam int LEN_W    = 7;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int DIV_W    = LEN_W + FRAC_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 1'd1;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	// result queue behind the arithmetic pipe
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
	} lrs_cmd_t;

	typedef struct packed {
		logic full;
		logic div_done;
		logic room;
		logic last_issue;
	} lrs_sts_t;

endpackage

// ===== rtl/lrs_ram.sv =====
module lrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/lrs_div.sv =====
module lrs_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lrs_pkg::DIV_W-1:0] dividend,
	input  logic [lrs_pkg::LEN_W-1:0] divisor,
	output logic                     done,
	output logic [lrs_pkg::DIV_W-1:0] quo,
	output logic [lrs_pkg::LEN_W-1:0] rem,
	output logic [lrs_pkg::LEN_W-1:0] rem_hi
);
	import lrs_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] num_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] hi_q;
	logic [LEN_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   rem_sh;
	logic             ge;
	logic [LEN_W-1:0] rem_n;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q, num_q[DIV_W-1]};
		ge     = rem_sh >= {1'b0, d_q};
		rem_n  = ge ? LEN_W'(rem_sh - {1'b0, d_q}) : rem_sh[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], ge};
			rem_q <= rem_n;
			// after the integer bits the partial remainder is the integer modulo
			if (cnt_q == CNT_W'(LEN_W - 1)) begin
				hi_q <= rem_n;
			end
		end
	end

	assign done   = done_q;
	assign quo    = num_q;
	assign rem    = rem_q;
	assign rem_hi = hi_q;

endmodule

// ===== rtl/lrs_ctrl.sv =====
module lrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lrs_pkg::lrs_sts_t sts,
	output lrs_pkg::lrs_cmd_t cmd
);
	import lrs_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		s_tready  = state_q == ST_LOAD;
		cmd.load  = s_tready && s_tvalid;
		cmd.start = cmd.load && sts.full;
		cmd.issue = (state_q == ST_EMIT) && sts.room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cmd.start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.issue && sts.last_issue) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// ===== rtl/lrs_dp.sv =====
module lrs_dp #(
	parameter int MAX_SOURCE = 64,
	parameter int MAX_TARGET = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrs_pkg::LEN_W-1:0]     cfg_data,
	input  logic [lrs_pkg::SAMPLE_W-1:0]  s_tdata,
	output logic [lrs_pkg::SAMPLE_W-1:0]  m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          m_tlast,
	input  lrs_pkg::lrs_cmd_t             cmd,
	output lrs_pkg::lrs_sts_t             sts
);
	import lrs_pkg::*;

	localparam int AW = $clog2(MAX_SOURCE);

	logic [LEN_W-1:0] src_q, tgt_q;
	logic [LEN_W-1:0] len_eff, tgt_eff;
	logic [LEN_W-1:0] load_cnt_q;

	logic [LEN_W-1:0] lm1_q, d_q, out_cnt_q;
	logic [LEN_W-1:0] idx_q, r_q, wr_q;
	logic [FRAC_W-1:0] w_q;

	logic             div_done;
	logic [DIV_W-1:0] quo;
	logic [LEN_W-1:0] rem, rem_hi;

	logic [LEN_W:0]   r_sum, wr_sum;
	logic             cr, cw;
	logic             at_end;
	logic [LEN_W-1:0] rd_idx_a, rd_idx_b;

	logic [SAMPLE_W-1:0] rd_a, rd_b;

	logic                v_s1, fin_s1;
	logic [FRAC_W-1:0]   w_s1;
	logic signed [SAMPLE_W:0]   diff_s1;
	logic signed [2*SAMPLE_W+1:0] prod_s1;

	logic                v_s2, fin_s2;
	logic signed [2*SAMPLE_W+1:0] prod_s2;
	logic [SAMPLE_W-1:0] s0_s2;
	logic signed [2*SAMPLE_W+1:0] rnd_s2;
	logic [SAMPLE_W-1:0] y_s2;

	logic [SAMPLE_W:0]   fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wptr_q, rptr_q;
	logic [FIFO_AW:0]    fcnt_q;
	logic                pop;
	logic [FIFO_AW:0]    pending;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= LEN_RESET;
			tgt_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_LENGTH: src_q <= cfg_data;
				REG_TARGET_LENGTH: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(src_q) > MAX_SOURCE) begin
			len_eff = LEN_W'(MAX_SOURCE);
		end else begin
			len_eff = src_q;
		end
		if (tgt_q < LEN_W'(2)) begin
			tgt_eff = LEN_W'(2);
		end else if (int'(tgt_q) > MAX_TARGET) begin
			tgt_eff = LEN_W'(MAX_TARGET);
		end else begin
			tgt_eff = tgt_q;
		end
	end

	// sample loading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (cmd.load) begin
			load_cnt_q <= sts.full ? '0 : load_cnt_q + LEN_W'(1);
		end
	end

	lrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend ({LEN_W'(len_eff - LEN_W'(1)), FRAC_W'(0)}),
		.divisor  (LEN_W'(tgt_eff - LEN_W'(1))),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem),
		.rem_hi   (rem_hi)
	);

	// position walk: idx/r is i*(L-1) over d, w/wr is r*65536 over d
	always_comb begin
		r_sum    = {1'b0, r_q} + {1'b0, rem_hi};
		cr       = r_sum >= {1'b0, d_q};
		wr_sum   = {1'b0, wr_q} + {1'b0, rem};
		cw       = wr_sum >= {1'b0, d_q};
		at_end   = idx_q >= lm1_q;
		rd_idx_a = at_end ? lm1_q : idx_q;
		// at the last sample both ports read it, so no entry past the block is read
		rd_idx_b = at_end ? lm1_q : idx_q + LEN_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lm1_q     <= len_eff - LEN_W'(1);
			d_q       <= tgt_eff - LEN_W'(1);
			out_cnt_q <= tgt_eff - LEN_W'(1);
			idx_q     <= '0;
			r_q       <= '0;
			w_q       <= '0;
			wr_q      <= '0;
		end else if (cmd.issue) begin
			out_cnt_q <= out_cnt_q - LEN_W'(1);
			r_q       <= cr ? LEN_W'(r_sum - {1'b0, d_q}) : r_sum[LEN_W-1:0];
			idx_q     <= idx_q + quo[DIV_W-1:FRAC_W] + LEN_W'(cr);
			wr_q      <= cw ? LEN_W'(wr_sum - {1'b0, d_q}) : wr_sum[LEN_W-1:0];
			w_q       <= w_q + quo[FRAC_W-1:0] + FRAC_W'(cw);
		end
	end

	lrs_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SOURCE)
	) u_ram (
		.clk     (clk),
		.we      (cmd.load),
		.waddr   (AW'(load_cnt_q)),
		.wdata   (s_tdata),
		.raddr_a (AW'(rd_idx_a)),
		.raddr_b (AW'(rd_idx_b)),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// s1: neighbor samples out of the ram, multiply by weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			w_s1   <= at_end ? '0 : w_q;
			fin_s1 <= sts.last_issue;
		end
	end

	always_comb begin
		diff_s1 = $signed({rd_b[SAMPLE_W-1], rd_b}) - $signed({rd_a[SAMPLE_W-1], rd_a});
		prod_s1 = diff_s1 * $signed({1'b0, w_s1});
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= prod_s1;
			s0_s2   <= rd_a;
			fin_s2  <= fin_s1;
		end
	end

	// s2: round to nearest, add base sample
	always_comb begin
		rnd_s2 = (prod_s2 + (2*SAMPLE_W+2)'(32768)) >>> FRAC_W;
		y_s2   = s0_s2 + rnd_s2[SAMPLE_W-1:0];
	end

	// result queue
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (v_s2) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			fcnt_q <= fcnt_q + (FIFO_AW+1)'(v_s2) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_mem[wptr_q] <= {fin_s2, y_s2};
		end
	end

	assign m_tvalid = fcnt_q != '0;
	assign m_tdata  = fifo_mem[rptr_q][SAMPLE_W-1:0];
	assign m_tlast  = fifo_mem[rptr_q][SAMPLE_W];

	// queue slots claimed by stored beats and by beats in flight
	assign pending = fcnt_q + (FIFO_AW+1)'(v_s1) + (FIFO_AW+1)'(v_s2);

	always_comb begin
		sts.full       = ({1'b0, load_cnt_q} + (LEN_W+1)'(1)) >= {1'b0, len_eff};
		sts.div_done   = div_done;
		sts.room       = pending < (FIFO_AW+1)'(FIFO_DEPTH);
		sts.last_issue = out_cnt_q == '0;
	end

endmodule

// ===== rtl/linear_resampler.sv =====
// Linear-interpolation resampler for blocks of signed 16-bit samples.
//
// Input stream s_*: one sample per beat. After source_length samples the
// block is closed and target_length resampled outputs leave on m_*, the
// last one of the block marked by m_tlast.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 source_length, 1 target_length) on the rising edge. Both reset to 64.
//
// Closing a block starts a restoring divider that finds the step of the
// interpolation position; s_tready is low from then until the last output
// has been issued. Outputs then issue one per cycle while the four-beat
// result queue has room, passing through the ram read, the multiply and
// the rounding add into it. The queue decouples the receiver: when
// m_tready is low issue stops once the queue is full, and loading of the
// next block may begin while the queue still drains.
// Reset clears the load count, the queue and the controller; the sample
// memory is not cleared.
module linear_resampler #(
	parameter int MAX_SOURCE = 64,
	parameter int MAX_TARGET = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrs_pkg::LEN_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lrs_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lrs_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out
	output logic                          m_tlast    // final_flag
);
	import lrs_pkg::*;

	lrs_cmd_t cmd;
	lrs_sts_t sts;

	lrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lrs_dp #(
		.MAX_SOURCE (MAX_SOURCE),
		.MAX_TARGET (MAX_TARGET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== rtl/lrs_checker.sv =====
module lrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lrs_pkg::SAMPLE_W-1:0]  m_tdata,
	input logic                          m_tlast
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// input is only closed right after a sample was taken
	a_close_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input closed without a sample beat");

	// the divide keeps input closed for a while
	a_div_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> ##16 !s_tready)
		else $error("input reopened before the divide finished");

endmodule

bind linear_resampler lrs_checker u_chk (.*);
